/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or implication property, sampled on clk, off during reset.
`define RTT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define RTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared constants, codes and controller/datapath interface types for the
// retransmit timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int MAX_OUT = 16;
	localparam int CNT_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

	// command codes
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_ACK    = 3'd1;
	localparam logic [2:0] CMD_CUM    = 3'd2;
	localparam logic [2:0] CMD_MARK   = 3'd3;
	localparam logic [2:0] CMD_DROP   = 3'd4;
	localparam logic [2:0] CMD_POLL   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_MAX_BUF = 3'd0;
	localparam logic [2:0] CFG_MAX_RET = 3'd1;
	localparam logic [2:0] CFG_FACTOR  = 3'd2;
	localparam logic [2:0] CFG_MIN_RTO = 3'd3;
	localparam logic [2:0] CFG_MAX_RTO = 3'd4;
	localparam logic [2:0] CFG_INIT    = 3'd5;
	localparam logic [2:0] CFG_ALPHA   = 3'd6;
	localparam logic [2:0] CFG_BETA    = 3'd7;

	// register reset values
	localparam logic [19:0] RST_MAX_BUF = 20'd1048575;
	localparam logic [3:0]  RST_MAX_RET = 4'd5;
	localparam logic [11:0] RST_FACTOR  = 12'd512;
	localparam logic [23:0] RST_MIN_RTO = 24'd200;
	localparam logic [23:0] RST_MAX_RTO = 24'd60000;
	localparam logic [23:0] RST_INIT    = 24'd1000;
	localparam logic [15:0] RST_ALPHA   = 16'd8192;
	localparam logic [15:0] RST_BETA    = 16'd16384;

	localparam logic [23:0] MASK24      = 24'hFFFFFF;
	localparam logic [39:0] BACKOFF_SAT = 40'hFF_FFFF_FFFF;
	localparam logic [4:0]  RETRY_MAX   = 5'd31;

	// RTT update step codes
	typedef logic [3:0] rtt_op_t;
	localparam rtt_op_t RO_NONE  = 4'd0;
	localparam rtt_op_t RO_SAMP  = 4'd1;
	localparam rtt_op_t RO_FIRST = 4'd2;
	localparam rtt_op_t RO_M1    = 4'd3;
	localparam rtt_op_t RO_M2    = 4'd4;
	localparam rtt_op_t RO_M3    = 4'd5;
	localparam rtt_op_t RO_M4    = 4'd6;
	localparam rtt_op_t RO_M5    = 4'd7;
	localparam rtt_op_t RO_CLAMP = 4'd8;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    scan_clr;
		logic    scan_step;
		logic    insert;
		logic    remove;
		logic    mark_inc;
		logic    bo_init;
		logic    bo_step;
		logic    bo_commit;
		logic    poll_push;
		logic    emit;
		logic    emit_ok;
		logic    emit_pend;
		rtt_op_t rtt_op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       scan_last;
		logic       found;
		logic       rtt_seen;
		logic       retry_zero;
		logic       retry_over;
		logic       bo_done;
		logic       out_free;
		logic       poll_full;
	} dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/retransmit_timer_table.sv */
// ----------------------------------------------------------------------------
// retransmit_timer_table
// Retransmission timer table over stream channels with a register write port.
// ----------------------------------------------------------------------------
// One command is taken at a time: s_tready is high only while the sequencer
// is idle, though a finished result may still sit in the output register.
// Each valid command walks all ENTRIES slots once, one slot a cycle,
// then acts: insert, drop and a failed lookup go on to the result; an
// ack that takes an RTT sample first runs the estimator, which runs its
// four products through one shared multiplier (the very first sample
// skips them); mark adds one backoff multiply per retry made, at most 15.
// Cumulative ack repeats the walk once per removed entry, and poll once
// per due entry it returns (up to 16). Results wait on m_tready.
// Configuration is accepted at any time.
`default_nettype none

module retransmit_timer_table (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [111:0] s_tdata,  // sequence_req[63:0], length[79:64], now_ms[111:80]
	input  wire logic [2:0]   s_tuser,  // command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [119:0]      m_tdata,  // due_sequence[63:0], due_retry_count[68:64],
	                                    // rto_ms[92:69], buffered_total[112:93], zero pad
	output logic              m_tuser,  // ok
	output logic              m_tlast,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);
	import rtt_pkg::*;

	dp_cmd_t     dcmd;
	dp_sts_t     dsts;
	logic        idle;
	logic [63:0] o_seq;
	logic [4:0]  o_rc;
	logic [23:0] o_rto;
	logic [19:0] o_bytes;

	assign s_tready  = idle;
	assign cfg_ready = 1'b1;

	rtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (s_tvalid && s_tready),
		.in_cmd    (s_tuser),
		.sts       (dsts),
		.c         (dcmd),
		.idle      (idle)
	);

	rtt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.c         (dcmd),
		.sts       (dsts),
		.in_cmd    (s_tuser),
		.in_seq    (s_tdata[63:0]),
		.in_len    (s_tdata[79:64]),
		.in_now    (s_tdata[111:80]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_ok    (m_tuser),
		.out_seq   (o_seq),
		.out_rc    (o_rc),
		.out_rto   (o_rto),
		.out_bytes (o_bytes),
		.out_last  (m_tlast)
	);

	// result beat packing
	assign m_tdata = {7'd0, o_bytes, o_rto, o_rc, o_seq};

endmodule

`default_nettype wire

/* hw/rtl/rtt_ctrl.sv */
// ----------------------------------------------------------------------------
// rtt_ctrl
// Sequencer for the timer table: scans, decisions, RTT update steps,
// backoff iterations and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_accept,
	input  wire logic [2:0]       in_cmd,
	input  wire rtt_pkg::dp_sts_t sts,
	output rtt_pkg::dp_cmd_t      c,
	output logic                  idle
);
	import rtt_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SCAN   = 5'd1;
	localparam logic [4:0] S_DECIDE = 5'd2;
	localparam logic [4:0] S_RSAMP  = 5'd3;
	localparam logic [4:0] S_RFIRST = 5'd4;
	localparam logic [4:0] S_R1     = 5'd5;
	localparam logic [4:0] S_R2     = 5'd6;
	localparam logic [4:0] S_R3     = 5'd7;
	localparam logic [4:0] S_R4     = 5'd8;
	localparam logic [4:0] S_R5     = 5'd9;
	localparam logic [4:0] S_RCLAMP = 5'd10;
	localparam logic [4:0] S_REMX   = 5'd11;
	localparam logic [4:0] S_BOCHK  = 5'd12;
	localparam logic [4:0] S_BO     = 5'd13;
	localparam logic [4:0] S_BOC    = 5'd14;
	localparam logic [4:0] S_POLLF  = 5'd15;
	localparam logic [4:0] S_EMIT   = 5'd16;
	localparam logic [4:0] S_EMITP  = 5'd17;

	logic [4:0] state_q, state_d;
	logic       ok_q, ok_d;

	assign idle = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		c       = '0;
		state_d = state_q;
		ok_d    = ok_q;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					c.load     = 1'b1;
					c.scan_clr = 1'b1;
					if (in_cmd <= CMD_POLL) begin
						state_d = S_SCAN;
					end else begin
						ok_d    = 1'b0;
						state_d = S_EMIT;
					end
				end
			end
			S_SCAN: begin
				c.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				case (sts.cmd)
					CMD_INSERT: begin
						c.insert = sts.found;
						ok_d     = sts.found;
						state_d  = S_EMIT;
					end
					CMD_ACK, CMD_CUM: begin
						if (sts.found) begin
							state_d = sts.retry_zero ? S_RSAMP : S_REMX;
						end else begin
							ok_d    = (sts.cmd == CMD_CUM);
							state_d = S_EMIT;
						end
					end
					CMD_MARK: begin
						if (sts.found) begin
							c.mark_inc = 1'b1;
							state_d    = S_BOCHK;
						end else begin
							ok_d    = 1'b0;
							state_d = S_EMIT;
						end
					end
					CMD_DROP: begin
						if (sts.found) begin
							state_d = S_REMX;
						end else begin
							ok_d    = 1'b0;
							state_d = S_EMIT;
						end
					end
					CMD_POLL: begin
						state_d = sts.found ? S_POLLF : S_EMITP;
					end
					default: begin
						ok_d    = 1'b0;
						state_d = S_EMIT;
					end
				endcase
			end
			S_RSAMP: begin
				c.rtt_op = RO_SAMP;
				state_d  = sts.rtt_seen ? S_R1 : S_RFIRST;
			end
			S_RFIRST: begin
				c.rtt_op = RO_FIRST;
				state_d  = S_RCLAMP;
			end
			S_R1: begin
				c.rtt_op = RO_M1;
				state_d  = S_R2;
			end
			S_R2: begin
				c.rtt_op = RO_M2;
				state_d  = S_R3;
			end
			S_R3: begin
				c.rtt_op = RO_M3;
				state_d  = S_R4;
			end
			S_R4: begin
				c.rtt_op = RO_M4;
				state_d  = S_R5;
			end
			S_R5: begin
				c.rtt_op = RO_M5;
				state_d  = S_RCLAMP;
			end
			S_RCLAMP: begin
				c.rtt_op = RO_CLAMP;
				state_d  = S_REMX;
			end
			S_REMX: begin
				c.remove = 1'b1;
				if (sts.cmd == CMD_CUM) begin
					c.scan_clr = 1'b1;
					state_d    = S_SCAN;
				end else begin
					ok_d    = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_BOCHK: begin
				if (sts.retry_over) begin
					ok_d    = 1'b0;
					state_d = S_EMIT;
				end else begin
					c.bo_init = 1'b1;
					state_d   = S_BO;
				end
			end
			S_BO: begin
				if (sts.bo_done) state_d = S_BOC;
				else c.bo_step = 1'b1;
			end
			S_BOC: begin
				c.bo_commit = 1'b1;
				ok_d        = 1'b1;
				state_d     = S_EMIT;
			end
			S_POLLF: begin
				// hand the previous due entry out, hold the new one back
				if (sts.out_free) begin
					c.poll_push = 1'b1;
					if (sts.poll_full) begin
						state_d = S_EMITP;
					end else begin
						c.scan_clr = 1'b1;
						state_d    = S_SCAN;
					end
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					c.emit    = 1'b1;
					c.emit_ok = ok_q;
					state_d   = S_IDLE;
				end
			end
			S_EMITP: begin
				if (sts.out_free) begin
					c.emit      = 1'b1;
					c.emit_pend = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rtt_dp.sv */
// ----------------------------------------------------------------------------
// rtt_dp
// Datapath: entry store, scan trackers, RTT estimator with one shared
// multiplier, backoff multiplier, configuration registers, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rtt_pkg::dp_cmd_t c,
	output rtt_pkg::dp_sts_t      sts,
	input  wire logic [2:0]       in_cmd,
	input  wire logic [63:0]      in_seq,
	input  wire logic [15:0]      in_len,
	input  wire logic [31:0]      in_now,
	input  wire logic             cfg_we,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [23:0]      cfg_data,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  out_ok,
	output logic [63:0]           out_seq,
	output logic [4:0]            out_rc,
	output logic [23:0]           out_rto,
	output logic [19:0]           out_bytes,
	output logic                  out_last
);
	import rtt_pkg::*;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUT - 1);
	localparam logic [16:0]      ONE_Q16  = 17'h10000;

	// configuration
	logic [19:0] max_buf_q;
	logic [3:0]  max_ret_q;
	logic [11:0] factor_q;
	logic [23:0] min_rto_q, max_rto_q;
	logic [15:0] alpha_q, beta_q;

	// captured item
	logic [2:0]  cmd_q;
	logic [63:0] seq_q;
	logic [15:0] len_q;
	logic [31:0] now_q;

	// entry store
	logic [ENTRIES-1:0] valid_q, taken_q;
	logic [63:0] ent_seq_q   [ENTRIES];
	logic [15:0] ent_len_q   [ENTRIES];
	logic [31:0] ent_first_q [ENTRIES];
	logic [31:0] ent_next_q  [ENTRIES];
	logic [4:0]  ent_ret_q   [ENTRIES];

	// scan trackers
	logic [IDX_W-1:0] idx_q, match_idx_q, free_idx_q, best_idx_q, sel;
	logic             match_v_q, free_v_q, best_v_q;
	logic [63:0]      best_seq_q;

	// estimator and backoff
	logic [23:0] srtt_q, dev_q, cto_q, s_q, diff_q;
	logic        seen_q;
	logic [40:0] prod_q, acc_q;
	logic [39:0] bo_q;
	logic [4:0]  bo_cnt_q;
	logic [19:0] bytes_q;

	// poll holding entry
	logic             pend_v_q;
	logic [63:0]      pend_seq_q;
	logic [4:0]       pend_rc_q;
	logic [CNT_W-1:0] cnt_q;

	// scan element view
	logic        e_valid, e_due, e_cand, e_better, e_match;
	logic [63:0] e_seq;
	logic [31:0] e_age;

	assign e_valid  = valid_q[idx_q];
	assign e_seq    = ent_seq_q[idx_q];
	assign e_age    = now_q - ent_next_q[idx_q];
	assign e_due    = ~e_age[31];
	assign e_match  = e_valid && (e_seq == seq_q);
	assign e_cand   = (cmd_q == CMD_POLL) ? (e_valid && !taken_q[idx_q] && e_due)
	                                      : (e_valid && (e_seq <= seq_q));
	assign e_better = e_cand && (!best_v_q || (e_seq < best_seq_q));

	// selected entry
	always_comb begin
		case (cmd_q)
			CMD_INSERT:                 sel = free_idx_q;
			CMD_ACK, CMD_MARK, CMD_DROP: sel = match_idx_q;
			default:                    sel = best_idx_q;
		endcase
	end

	logic [20:0] bytes_sum;
	logic        ins_ok, found;
	assign bytes_sum = {1'b0, bytes_q} + {5'd0, len_q};
	assign ins_ok    = (bytes_sum <= {1'b0, max_buf_q}) && !match_v_q && free_v_q;

	always_comb begin
		case (cmd_q)
			CMD_INSERT:                 found = ins_ok;
			CMD_ACK, CMD_MARK, CMD_DROP: found = match_v_q;
			default:                    found = best_v_q;
		endcase
	end

	logic out_free;
	assign out_free = !out_valid || out_ready;

	assign sts.cmd        = cmd_q;
	assign sts.scan_last  = (idx_q == IDX_LAST);
	assign sts.found      = found;
	assign sts.rtt_seen   = seen_q;
	assign sts.retry_zero = (ent_ret_q[sel] == 5'd0);
	assign sts.retry_over = (ent_ret_q[sel] > {1'b0, max_ret_q});
	assign sts.bo_done    = (bo_cnt_q == ent_ret_q[sel]);
	assign sts.out_free   = out_free;
	assign sts.poll_full  = (cnt_q == CNT_LAST);

	// sample, shared multiplier operands, sums
	logic [31:0] age;
	logic [23:0] samp;
	logic [16:0] mul_a;
	logic [23:0] mul_b;
	logic [40:0] mul_p;
	logic [41:0] acc_sum;
	logic [26:0] rto_raw;
	logic [23:0] rto_clamped;

	assign age     = now_q - ent_first_q[sel];
	assign samp    = (age > {8'd0, MASK24}) ? MASK24 : age[23:0];
	assign acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
	assign rto_raw = {3'd0, srtt_q} + {1'b0, dev_q, 2'b00};

	always_comb begin
		case (c.rtt_op)
			RO_M1:   begin mul_a = ONE_Q16 - {1'b0, beta_q};  mul_b = dev_q;  end
			RO_M2:   begin mul_a = {1'b0, beta_q};            mul_b = diff_q; end
			RO_M3:   begin mul_a = ONE_Q16 - {1'b0, alpha_q}; mul_b = srtt_q; end
			RO_M4:   begin mul_a = {1'b0, alpha_q};           mul_b = s_q;    end
			default: begin mul_a = '0;                        mul_b = '0;     end
		endcase
	end
	assign mul_p = {24'd0, mul_a} * {17'd0, mul_b};

	always_comb begin
		if (rto_raw < {3'd0, min_rto_q})      rto_clamped = min_rto_q;
		else if (rto_raw > {3'd0, max_rto_q}) rto_clamped = max_rto_q;
		else                                  rto_clamped = rto_raw[23:0];
	end

	// backoff step
	logic [51:0] bo_prod;
	logic [39:0] bo_next;
	logic [23:0] bo_capped;
	assign bo_prod   = {12'd0, bo_q} * {40'd0, factor_q};
	assign bo_next   = (bo_prod[51:8] > {4'd0, BACKOFF_SAT}) ? BACKOFF_SAT : bo_prod[47:8];
	assign bo_capped = (bo_q > {16'd0, max_rto_q}) ? max_rto_q : bo_q[23:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_buf_q <= RST_MAX_BUF;
			max_ret_q <= RST_MAX_RET;
			factor_q  <= RST_FACTOR;
			min_rto_q <= RST_MIN_RTO;
			max_rto_q <= RST_MAX_RTO;
			alpha_q   <= RST_ALPHA;
			beta_q    <= RST_BETA;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_BUF: max_buf_q <= cfg_data[19:0];
				CFG_MAX_RET: max_ret_q <= cfg_data[3:0];
				CFG_FACTOR:  factor_q  <= cfg_data[11:0];
				CFG_MIN_RTO: min_rto_q <= cfg_data;
				CFG_MAX_RTO: max_rto_q <= cfg_data;
				CFG_INIT:    ; // the initial timeout only takes effect at reset
				CFG_ALPHA:   alpha_q   <= cfg_data[15:0];
				CFG_BETA:    beta_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// item capture, working registers without reset
	always_ff @(posedge clk) begin
		if (c.load) begin
			cmd_q <= in_cmd;
			seq_q <= in_seq;
			len_q <= in_len;
			now_q <= in_now;
		end
		if (c.scan_step && e_better) best_seq_q <= e_seq;
		if (c.scan_step && e_match && !match_v_q) match_idx_q <= idx_q;
		if (c.scan_step && !e_valid && !free_v_q) free_idx_q <= idx_q;
		if (c.scan_step && e_better) best_idx_q <= idx_q;
		// estimator steps
		case (c.rtt_op)
			RO_SAMP: s_q <= samp;
			RO_M1: begin
				prod_q <= mul_p;
				diff_q <= (srtt_q > s_q) ? (srtt_q - s_q) : (s_q - srtt_q);
			end
			RO_M2, RO_M4: begin
				acc_q  <= prod_q;
				prod_q <= mul_p;
			end
			RO_M3:   prod_q <= mul_p;
			default: ;
		endcase
		// backoff iterations
		if (c.bo_init) begin
			bo_q     <= {16'd0, cto_q};
			bo_cnt_q <= 5'd0;
		end else if (c.bo_step) begin
			bo_q     <= bo_next;
			bo_cnt_q <= bo_cnt_q + 5'd1;
		end
		// entry fields
		if (c.insert) begin
			ent_seq_q[sel]   <= seq_q;
			ent_len_q[sel]   <= len_q;
			ent_first_q[sel] <= now_q;
			ent_next_q[sel]  <= now_q + {8'd0, cto_q};
			ent_ret_q[sel]   <= 5'd0;
		end
		if (c.mark_inc && (ent_ret_q[sel] != RETRY_MAX)) ent_ret_q[sel] <= ent_ret_q[sel] + 5'd1;
		if (c.bo_commit) ent_next_q[sel] <= now_q + {8'd0, bo_capped};
		if (c.poll_push) begin
			pend_seq_q <= best_seq_q;
			pend_rc_q  <= ent_ret_q[sel];
		end
	end

	// scan control, valid and taken bits, estimator state, byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			match_v_q <= 1'b0;
			free_v_q  <= 1'b0;
			best_v_q  <= 1'b0;
			valid_q   <= '0;
			taken_q   <= '0;
			pend_v_q  <= 1'b0;
			cnt_q     <= '0;
			srtt_q    <= RST_INIT;
			dev_q     <= '0;
			cto_q     <= RST_INIT;
			seen_q    <= 1'b0;
			bytes_q   <= '0;
		end else begin
			if (c.scan_clr) begin
				idx_q     <= '0;
				match_v_q <= 1'b0;
				free_v_q  <= 1'b0;
				best_v_q  <= 1'b0;
			end else if (c.scan_step) begin
				idx_q <= idx_q + 1'b1;
				if (e_match) match_v_q <= 1'b1;
				if (!e_valid) free_v_q <= 1'b1;
				if (e_better) best_v_q <= 1'b1;
			end
			if (c.load) begin
				taken_q  <= '0;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end
			if (c.poll_push) begin
				taken_q[sel] <= 1'b1;
				pend_v_q     <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end
			if (c.insert) begin
				valid_q[sel] <= 1'b1;
				bytes_q      <= bytes_sum[19:0];
			end
			if (c.remove) begin
				valid_q[sel] <= 1'b0;
				bytes_q      <= bytes_q - {4'd0, ent_len_q[sel]};
			end
			case (c.rtt_op)
				RO_FIRST: begin
					srtt_q <= s_q;
					dev_q  <= {1'b0, s_q[23:1]};
					seen_q <= 1'b1;
				end
				RO_M3:    dev_q  <= acc_sum[39:16];
				RO_M5:    srtt_q <= acc_sum[39:16];
				RO_CLAMP: cto_q  <= rto_clamped;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (c.emit || (c.poll_push && pend_v_q)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.poll_push && pend_v_q) begin
			out_ok    <= 1'b1;
			out_seq   <= pend_seq_q;
			out_rc    <= pend_rc_q;
			out_last  <= 1'b0;
			out_rto   <= cto_q;
			out_bytes <= bytes_q;
		end else if (c.emit) begin
			out_ok    <= c.emit_pend ? pend_v_q : c.emit_ok;
			out_seq   <= (c.emit_pend && pend_v_q) ? pend_seq_q : 64'd0;
			out_rc    <= (c.emit_pend && pend_v_q) ? pend_rc_q : 5'd0;
			out_last  <= 1'b1;
			out_rto   <= cto_q;
			out_bytes <= bytes_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/rtt_chk.sv */
// ----------------------------------------------------------------------------
// rtt_chk
// Port-level checker for the retransmit timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtt_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [119:0] m_tdata,
	input wire logic         m_tuser,
	input wire logic         m_tlast
);

	// one command in flight: ready drops after a beat is taken
	`RTT_ASSERT_NEXT(a_one_cmd, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// a stalled result beat holds
	`RTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")

	// a failed or empty result always closes the command
	`RTT_ASSERT(a_fail_last, !(m_tvalid && !m_tuser) || m_tlast, "failure not final")

	// a failed result carries no due packet
	`RTT_ASSERT(a_fail_zero, !(m_tvalid && !m_tuser) || (m_tdata[68:0] == 69'd0), "due fields set on failure")

endmodule

bind retransmit_timer_table rtt_chk u_rtt_chk (.*);

`default_nettype wire
